FILE: sv/rdm_pkg.sv
// Package for the maze generator: grid sizes, wall codes, sequencer states
// and the small arithmetic helpers used by the top level.
// No dependencies.
package rdm_pkg;

	localparam int GRID_WIDTH  = 20;
	localparam int GRID_HEIGHT = 9;
	localparam int STACK_DEPTH = 256;

	localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
	localparam int X_W        = 5;
	localparam int Y_W        = 4;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int LEVEL_W    = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW     = $clog2(STACK_DEPTH);
	localparam int WALL_W     = 4;
	localparam int SEED_W     = 32;
	localparam int RND_W      = 15;

	localparam logic [SEED_W-1:0] LCG_MUL = 32'd1103515245;
	localparam logic [SEED_W-1:0] LCG_INC = 32'd12345;

	localparam logic [WALL_W-1:0] WALL_TOP    = 4'b0001;
	localparam logic [WALL_W-1:0] WALL_RIGHT  = 4'b0010;
	localparam logic [WALL_W-1:0] WALL_BOTTOM = 4'b0100;
	localparam logic [WALL_W-1:0] WALL_LEFT   = 4'b1000;
	localparam logic [WALL_W-1:0] ALL_WALLS   = 4'b1111;

	localparam logic REQ_GEN  = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT
	} dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_SCAN,
		ST_STEP,
		ST_PICK,
		ST_CARVE_TOP,
		ST_CARVE_NB,
		ST_POP,
		ST_POP_WAIT,
		ST_FIN_TOP,
		ST_FIN_BOT
	} state_t;

	function automatic logic [CELL_W-1:0] cell_idx(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		return CELL_W'(int'(y) * GRID_WIDTH + int'(x));
	endfunction

	function automatic logic [WALL_W-1:0] dir_wall(input dir_t d);
		logic [WALL_W-1:0] w;
		unique case (d)
			DIR_UP:    w = WALL_TOP;
			DIR_RIGHT: w = WALL_RIGHT;
			DIR_DOWN:  w = WALL_BOTTOM;
			DIR_LEFT:  w = WALL_LEFT;
		endcase
		return w;
	endfunction

	function automatic logic [WALL_W-1:0] dir_back(input dir_t d);
		logic [WALL_W-1:0] w;
		unique case (d)
			DIR_UP:    w = WALL_BOTTOM;
			DIR_RIGHT: w = WALL_LEFT;
			DIR_DOWN:  w = WALL_TOP;
			DIR_LEFT:  w = WALL_RIGHT;
		endcase
		return w;
	endfunction

	// 4 = 1 mod 3, so base-4 digits fold without changing the residue
	function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
		logic [15:0] p;
		logic [4:0]  s;
		logic [2:0]  t;
		logic [2:0]  u;
		p = {1'b0, v};
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(p[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		u = 3'(t[1:0]) + 3'(t[2]);
		return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
	endfunction

	function automatic logic [1:0] pick_mod(input logic [RND_W-1:0] r,
			input logic [2:0] cnt);
		logic [1:0] m;
		unique case (cnt)
			3'd2:    m = {1'b0, r[0]};
			3'd3:    m = mod3(r);
			3'd4:    m = r[1:0];
			default: m = 2'd0;
		endcase
		return m;
	endfunction

endpackage

FILE: sv/rdm_req_if.sv
// Request channel of the maze generator: valid/ready plus the request item.
// Depends on rdm_pkg.
interface rdm_req_if;
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	logic [rdm_pkg::X_W-1:0] cell_x;
	logic [rdm_pkg::Y_W-1:0] cell_y;

	modport source (output valid, output req_type, output cell_x, output cell_y,
		input ready);
	modport sink (input valid, input req_type, input cell_x, input cell_y,
		output ready);
endinterface

FILE: sv/rdm_rsp_if.sv
// Response channel of the maze generator: valid/ready plus the result item.
// Depends on rdm_pkg.
interface rdm_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [rdm_pkg::WALL_W-1:0] wall_bits;
	logic                      gen_done;

	modport source (output valid, output wall_bits, output gen_done, input ready);
	modport sink (input valid, input wall_bits, input gen_done, output ready);
endinterface

FILE: sv/random_dfs_maze_generator.sv
// Depth-first maze generator with a wall store and an explicit path stack.
// Read item: wall store read register, then result register (out-of-grid reads
// load the result register directly). Generate item: each carved cell runs the
// neighbour scan, step, pick, carve-top and carve-neighbour states, each backtrack
// the scan, pop and pop-wait states. The wall store has a single read port. One item at a time.
// Async reset clears the sequencer, visited flags (all cells read as 4 walls).
module random_dfs_maze_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rdm_pkg::SEED_W-1:0]  cfg_wdata,
	rdm_req_if.sink                     req,
	rdm_rsp_if.source                   rsp
);
	import rdm_pkg::*;

	state_t state_q, state_d;

	logic [SEED_W-1:0]     seed_q;
	logic [SEED_W-1:0]     lcg_q;
	logic [CELL_COUNT-1:0] visited_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [X_W-1:0]        cur_x_q, nb_x_q;
	logic [Y_W-1:0]        cur_y_q, nb_y_q;
	dir_t                  scan_q, dir_q;
	dir_t                  cand_q [4];
	logic [2:0]            cnt_q;
	logic [CELL_W-1:0]     rd_idx_q;
	logic                  out_valid_q;
	logic [WALL_W-1:0]     out_wall_q;
	logic                  out_gen_q;

	// wall store and path stack
	logic [WALL_W-1:0]     cell_mem_q [CELL_COUNT];
	logic [WALL_W-1:0]     cell_rd_q;
	logic [X_W+Y_W-1:0]    stack_mem_q [STACK_DEPTH];
	logic [X_W+Y_W-1:0]    stack_rd_q;

	logic                  mem_we;
	logic [CELL_W-1:0]     mem_waddr, mem_raddr;
	logic [WALL_W-1:0]     mem_wdata;
	logic                  stk_we;
	logic [STK_AW-1:0]     stk_raddr;

	logic                  in_acc;
	logic                  req_in_grid;
	logic [CELL_W-1:0]     req_idx, cur_idx, nb_idx, nb_q_idx;
	dir_t                  nb_dir, pick_dir;
	logic [1:0]            pick_sel;
	logic                  nb_ok, nb_free;
	logic [X_W-1:0]        nb_x;
	logic [Y_W-1:0]        nb_y;
	logic [2:0]            cnt_nx;

	assign req.ready   = (state_q == ST_IDLE) && !out_valid_q;
	assign in_acc      = req.valid && req.ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.wall_bits = out_wall_q;
	assign rsp.gen_done  = out_gen_q;

	assign req_in_grid = (int'(req.cell_x) < GRID_WIDTH) && (int'(req.cell_y) < GRID_HEIGHT);
	assign req_idx     = cell_idx(req.cell_x, req.cell_y);
	assign cur_idx     = cell_idx(cur_x_q, cur_y_q);
	assign nb_q_idx    = cell_idx(nb_x_q, nb_y_q);
	assign pick_sel    = pick_mod(lcg_q[30:16], cnt_q);
	assign pick_dir    = cand_q[pick_sel];
	assign nb_dir      = (state_q == ST_SCAN) ? scan_q : pick_dir;

	// shared neighbour unit: scan uses it one direction a cycle, pick once
	always_comb begin
		nb_ok = 1'b0;
		nb_x  = cur_x_q;
		nb_y  = cur_y_q;
		unique case (nb_dir)
			DIR_UP: begin
				nb_ok = (cur_y_q != '0);
				if (nb_ok) nb_y = cur_y_q - Y_W'(1);
			end
			DIR_RIGHT: begin
				nb_ok = (int'(cur_x_q) != GRID_WIDTH - 1);
				if (nb_ok) nb_x = cur_x_q + X_W'(1);
			end
			DIR_DOWN: begin
				nb_ok = (int'(cur_y_q) != GRID_HEIGHT - 1);
				if (nb_ok) nb_y = cur_y_q + Y_W'(1);
			end
			DIR_LEFT: begin
				nb_ok = (cur_x_q != '0);
				if (nb_ok) nb_x = cur_x_q - X_W'(1);
			end
		endcase
	end

	assign nb_idx  = cell_idx(nb_x, nb_y);
	assign nb_free = nb_ok && !visited_q[nb_idx];
	assign cnt_nx  = cnt_q + 3'(nb_free);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = cur_idx;
		mem_wdata = ALL_WALLS;
		mem_raddr = cur_idx;
		stk_we    = 1'b0;
		stk_raddr = STK_AW'(level_q - LEVEL_W'(2));
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (req.req_type == REQ_READ) begin
						mem_raddr = req_idx;
						if (req_in_grid) state_d = ST_RD_WAIT;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						state_d   = ST_SCAN;
					end
				end
			end
			ST_RD_WAIT: state_d = ST_IDLE;
			ST_SCAN: begin
				if (scan_q == DIR_LEFT) state_d = (cnt_nx != 3'd0) ? ST_STEP : ST_POP;
			end
			ST_STEP: state_d = ST_PICK;
			ST_PICK: state_d = ST_CARVE_TOP;
			ST_CARVE_TOP: begin
				mem_we    = 1'b1;
				mem_wdata = cell_rd_q & ~dir_wall(dir_q);
				state_d   = ST_CARVE_NB;
			end
			ST_CARVE_NB: begin
				mem_we    = 1'b1;
				mem_waddr = nb_q_idx;
				mem_wdata = ALL_WALLS & ~dir_back(dir_q);
				stk_we    = (level_q < LEVEL_W'(STACK_DEPTH));
				state_d   = ST_SCAN;
			end
			ST_POP: begin
				if (level_q == LEVEL_W'(1)) begin
					mem_raddr = '0;
					state_d   = ST_FIN_TOP;
				end else begin
					state_d = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: state_d = ST_SCAN;
			ST_FIN_TOP: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				mem_wdata = cell_rd_q & ~WALL_TOP;
				mem_raddr = CELL_W'(CELL_COUNT - 1);
				state_d   = ST_FIN_BOT;
			end
			ST_FIN_BOT: begin
				mem_we    = 1'b1;
				mem_waddr = CELL_W'(CELL_COUNT - 1);
				mem_wdata = cell_rd_q & ~WALL_BOTTOM;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) cell_mem_q[mem_waddr] <= mem_wdata;
		cell_rd_q <= cell_mem_q[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stack_mem_q[level_q[STK_AW-1:0]] <= {nb_y_q, nb_x_q};
		stack_rd_q <= stack_mem_q[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= '0;
			lcg_q       <= '0;
			visited_q   <= '0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) seed_q <= cfg_wdata;
			if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && req.req_type == REQ_GEN) begin
						lcg_q     <= LCG_INC + seed_q;
						visited_q <= CELL_COUNT'(1);
						level_q   <= LEVEL_W'(1);
					end else if (in_acc && !req_in_grid) begin
						out_valid_q <= 1'b1;
					end
				end
				ST_RD_WAIT: out_valid_q <= 1'b1;
				ST_STEP:    lcg_q <= lcg_q * LCG_MUL + LCG_INC;
				ST_CARVE_NB: begin
					visited_q[nb_q_idx] <= 1'b1;
					if (level_q < LEVEL_W'(STACK_DEPTH)) level_q <= level_q + LEVEL_W'(1);
				end
				ST_POP:     level_q <= level_q - LEVEL_W'(1);
				ST_FIN_BOT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_x_q  <= '0;
				cur_y_q  <= '0;
				scan_q   <= DIR_UP;
				cnt_q    <= '0;
				rd_idx_q <= req_idx;
				if (in_acc) begin
					out_wall_q <= '0;
					out_gen_q  <= (req.req_type == REQ_GEN);
				end
			end
			ST_RD_WAIT: begin
				out_wall_q <= visited_q[rd_idx_q] ? cell_rd_q : ALL_WALLS;
				out_gen_q  <= 1'b0;
			end
			ST_SCAN: begin
				if (nb_free) cand_q[cnt_q[1:0]] <= scan_q;
				cnt_q  <= cnt_nx;
				scan_q <= dir_t'(scan_q + 2'd1);
			end
			ST_PICK: begin
				dir_q  <= pick_dir;
				nb_x_q <= nb_x;
				nb_y_q <= nb_y;
			end
			ST_CARVE_NB: begin
				cnt_q <= '0;
				if (level_q < LEVEL_W'(STACK_DEPTH)) begin
					cur_x_q <= nb_x_q;
					cur_y_q <= nb_y_q;
				end
			end
			ST_POP_WAIT: begin
				cnt_q <= '0;
				// the bottom entry is always the entrance cell and is never stored
				if (level_q == LEVEL_W'(1)) begin
					cur_x_q <= '0;
					cur_y_q <= '0;
				end else begin
					cur_x_q <= stack_rd_q[X_W-1:0];
					cur_y_q <= stack_rd_q[X_W+Y_W-1:X_W];
				end
			end
			ST_FIN_BOT: begin
				out_wall_q <= '0;
				out_gen_q  <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule

FILE: tb/sv/maze_checker.sv
`timescale 1ns / 1ps
// Checker for the maze generator: watches the request, response and register write
// ports, keeps its own copy of the maze and compares every response item.
// Depends on rdm_pkg, rdm_req_if and rdm_rsp_if.
module maze_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rdm_pkg::SEED_W-1:0] cfg_wdata,
	rdm_req_if                         req,
	rdm_rsp_if                         rsp,
	output int                         fail_count,
	output int                         pending
);
	import rdm_pkg::*;

	localparam logic [4:0] VISITED = 5'h10;

	typedef struct packed {
		logic [WALL_W-1:0] walls;
		logic              done;
	} maze_result_t;

	maze_result_t      due_results[$];
	logic [4:0]        cells[CELL_COUNT];
	logic [CELL_W-1:0] trail[STACK_DEPTH];
	int unsigned       depth;
	logic [SEED_W-1:0] lcg;
	logic [SEED_W-1:0] seed;
	int                seen;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] response %0d: %s got %0d, expected %0d", $realtime, seen, what, got,
			want);
		fail_count++;
	endtask

	// Recursive backtracker over the whole grid, seeded from the tick register
	function automatic void carve_maze();
		int unsigned       here;
		int unsigned       n_free;
		int unsigned       pick;
		int                cx;
		int                cy;
		int                nx;
		int                ny;
		int unsigned       cand_cell[4];
		logic [WALL_W-1:0] cand_wall[4];
		logic [WALL_W-1:0] cand_back[4];
		logic [RND_W-1:0]  rnd;
		lcg = LCG_INC + seed;
		foreach (cells[i]) cells[i] = {1'b0, ALL_WALLS};
		trail[0] = '0;
		depth = 1;
		cells[0] = cells[0] | VISITED;
		while (depth > 0) begin
			here = trail[depth - 1];
			cx = here % GRID_WIDTH;
			cy = here / GRID_WIDTH;
			n_free = 0;
			// candidates listed up, right, down, left
			for (int d = 0; d < 4; d++) begin
				nx = cx;
				ny = cy;
				case (dir_t'(d))
					DIR_UP: begin
						ny = cy - 1;
						cand_wall[n_free] = WALL_TOP;
						cand_back[n_free] = WALL_BOTTOM;
					end
					DIR_RIGHT: begin
						nx = cx + 1;
						cand_wall[n_free] = WALL_RIGHT;
						cand_back[n_free] = WALL_LEFT;
					end
					DIR_DOWN: begin
						ny = cy + 1;
						cand_wall[n_free] = WALL_BOTTOM;
						cand_back[n_free] = WALL_TOP;
					end
					default: begin
						nx = cx - 1;
						cand_wall[n_free] = WALL_LEFT;
						cand_back[n_free] = WALL_RIGHT;
					end
				endcase
				if (nx >= 0 && nx < GRID_WIDTH && ny >= 0 && ny < GRID_HEIGHT) begin
					if (!cells[ny * GRID_WIDTH + nx][4]) begin
						cand_cell[n_free] = ny * GRID_WIDTH + nx;
						n_free++;
					end
				end
			end
			if (n_free > 0) begin
				lcg = lcg * LCG_MUL + LCG_INC;
				rnd = lcg[30:16];
				pick = rnd % n_free;
				cells[here] = cells[here] & ~{1'b0, cand_wall[pick]};
				cells[cand_cell[pick]] = (cells[cand_cell[pick]] & ~{1'b0, cand_back[pick]})
					| VISITED;
				// a full stack leaves the new cell as a dead end
				if (depth < STACK_DEPTH) begin
					trail[depth] = CELL_W'(cand_cell[pick]);
					depth++;
				end
			end else begin
				depth--;
			end
		end
		cells[0] = cells[0] & ~{1'b0, WALL_TOP};
		cells[CELL_COUNT - 1] = cells[CELL_COUNT - 1] & ~{1'b0, WALL_BOTTOM};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		maze_result_t got;
		maze_result_t want;
		if (!arst_n) begin
			foreach (cells[i]) cells[i] = {1'b0, ALL_WALLS};
			depth = 0;
			lcg = '0;
			seed = '0;
			seen = 0;
			due_results.delete();
		end else begin
			if (cfg_we)
				seed = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				got.walls = rsp.wall_bits;
				got.done = rsp.gen_done;
				if (due_results.size() == 0) begin
					report_mismatch("unexpected item, wall_bits", got.walls, 0);
				end else begin
					want = due_results.pop_front();
					if (got.walls !== want.walls)
						report_mismatch("wall_bits", got.walls, want.walls);
					if (got.done !== want.done)
						report_mismatch("gen_done", got.done, want.done);
				end
				seen++;
			end
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_GEN) begin
					carve_maze();
					want.walls = '0;
					want.done = 1'b1;
				end else begin
					want.done = 1'b0;
					if (req.cell_x < GRID_WIDTH && req.cell_y < GRID_HEIGHT)
						want.walls = cells[int'(req.cell_y) * GRID_WIDTH + int'(req.cell_x)][3:0];
					else
						want.walls = '0;
				end
				due_results.push_back(want);
			end
		end
		pending = due_results.size();
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the maze generator testbench: clock, reset, register writes, request
// and response handshakes, watchdog and verdict.
// Depends on rdm_pkg, the two channel interfaces, maze_checker and the block.
module testbench;
	import rdm_pkg::*;

	localparam int WATCHDOG_LIMIT = 25000;
	localparam int LONG_HOLD      = 400;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 59;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [SEED_W-1:0] cfg_wdata;
	int                fail_count;
	int                pending;
	int                sent;
	int                got;
	int                n_gen;
	int                n_read;
	int                n_outside;
	int                n_seed;
	int                quiet;

	rdm_req_if req_ch ();
	rdm_rsp_if rsp_ch ();

	random_dfs_maze_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	maze_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	// every fourth stretch of 25 items runs with no idling at all
	function automatic bit idle_on(input int n);
		return (n / 25) % 4 != 3;
	endfunction

	task automatic send_item(input logic kind, input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		int gap;
		gap = idle_on(sent) ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.req_type = kind;
		req_ch.cell_x = x;
		req_ch.cell_y = y;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		sent++;
		if (kind == REQ_GEN) begin
			n_gen++;
		end else begin
			n_read++;
			if (x >= GRID_WIDTH || y >= GRID_HEIGHT)
				n_outside++;
		end
	endtask

	// the register is only touched once every response item is back
	task automatic load_seed(input logic [SEED_W-1:0] value);
		req_ch.valid = 1'b0;
		wait (pending == 0);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		n_seed++;
	endtask

	task automatic send_random();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			send_item(REQ_GEN, X_W'($urandom()), Y_W'($urandom()));
		else if (roll < 88)
			send_item(REQ_READ, X_W'($urandom_range(0, GRID_WIDTH - 1)),
				Y_W'($urandom_range(0, GRID_HEIGHT - 1)));
		else
			send_item(REQ_READ, X_W'($urandom_range(0, 31)), Y_W'($urandom_range(0, 15)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_READ;
		req_ch.cell_x = '0;
		req_ch.cell_y = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// untouched store reads as four walls in every grid cell, outside the grid as none
		load_seed(32'h0000_0000);
		send_item(REQ_READ, 5'd0, 4'd0);
		send_item(REQ_READ, 5'd19, 4'd8);
		send_item(REQ_READ, 5'd31, 4'd15);
		send_item(REQ_GEN, 5'd0, 4'd0);
		send_item(REQ_READ, 5'd0, 4'd0);
		send_item(REQ_READ, 5'd19, 4'd8);
		send_item(REQ_READ, 5'd19, 4'd0);
		send_item(REQ_READ, 5'd0, 4'd8);
		send_item(REQ_READ, 5'd20, 4'd8);
		send_item(REQ_READ, 5'd19, 4'd9);
		send_item(REQ_READ, 5'd31, 4'd0);
		send_item(REQ_READ, 5'd0, 4'd15);
		load_seed(32'hFFFF_FFFF);
		send_item(REQ_GEN, 5'd31, 4'd15);
		send_item(REQ_READ, 5'd0, 4'd0);
		send_item(REQ_READ, 5'd19, 4'd8);
		send_item(REQ_READ, 5'd10, 4'd4);
		// seed that wraps the generator start to zero
		load_seed(32'hFFFF_CFC7);
		send_item(REQ_GEN, 5'd21, 4'd10);
		send_item(REQ_READ, 5'd0, 4'd0);
		send_item(REQ_READ, 5'd1, 4'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			load_seed(ph == 2 ? 32'h8000_0000 : $urandom());
			send_item(REQ_GEN, X_W'($urandom()), Y_W'($urandom()));
			repeat (PHASE_ITEMS) send_random();
		end

		req_ch.valid = 1'b0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		$display("Covered %0d generate and %0d read items (%0d outside the grid)",
			n_gen, n_read, n_outside);
		$display("under %0d tick seeds, with random gaps, stalls and long response hold-offs",
			n_seed);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// response side: random stalls, plus two long hold-offs that back up the input
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (got == 30 || got == 150)
				stall = LONG_HOLD;
			else
				stall = idle_on(got) ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got++;
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d items outstanding", quiet,
				pending);
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

FILE: filelist.f
sv/rdm_pkg.sv
sv/rdm_req_if.sv
sv/rdm_rsp_if.sv
sv/random_dfs_maze_generator.sv
tb/sv/maze_checker.sv
tb/sv/testbench.sv
